// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define AST_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_ALWAYS(label, clk, rst_n, expr, msg)
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg)
`define AST_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// Constants and helpers for the signed integer to radix text unit.
// ----------------------------------------------------------------------------
package sirt_pkg;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_SIZE    = 2'd0;
    localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

    typedef logic [7:0] t_char;

    // pick one alphabet byte: 0..7 from the low word, 8..15 from the high word
    function automatic t_char sym_at(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [3:0] idx);
        logic [63:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/signed_int_to_radix_text_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_unit
// Converts a signed integer into its text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// One value is taken at a time; o_stall stays high until the last character
// has been loaded into the output register. Per value the unit first checks
// the alphabet one symbol pair per cycle (n*(n+1)/2 pairs for radix n, at
// most 136), stopping at the first bad pair, then peels off digits with a
// shared bit-serial restoring divider (up to VALUE_BITS digits), then sends one
// character per cycle while the output is not stalled. The longest text comes
// from the most negative 32-bit value in base 2 (three pair checks, 32 digits,
// 33 characters). Characters leave most significant digit first, a minus
// sign before negatives, and o_last_char marks the final one. An invalid
// base size or alphabet gives a single transfer with o_base_invalid set and
// o_symbol zero.
`include "assert_macros.svh"

module signed_int_to_radix_text_unit #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_symbol,
    output logic        o_last_char,
    output logic        o_base_invalid
);

    localparam int RW = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1; // digit width
    localparam int BW = RW + 1;                                  // radix width
    localparam int CW = $clog2(VALUE_BITS);                      // bit counter
    localparam int SW = $clog2(VALUE_BITS);                      // stack index
    localparam int NW = $clog2(VALUE_BITS + 1);                  // stack count

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_FLAG  = 3'd4;

    // configuration registers
    logic [4:0]  r_base_size;
    logic [63:0] r_sym_lo;
    logic [63:0] r_sym_hi;

    // sequencer and datapath
    logic [2:0]            r_state, n_state;
    logic [RW-1:0]         r_i, n_i;
    logic [RW-1:0]         r_j, n_j;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [RW-1:0]         r_rem, n_rem;
    logic [CW-1:0]         r_bit, n_bit;
    logic [NW-1:0]         r_nd, n_nd;
    logic                  r_neg, n_neg;
    logic [RW-1:0]         r_digits [VALUE_BITS];

    // output register
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_symbol, n_symbol;
    logic       r_last, n_last;
    logic       r_bad, n_bad;

    logic                  accept;
    logic                  out_free;
    logic                  base_bad;
    logic [RW-1:0]         last_idx;
    logic [BW-1:0]         radix;
    logic [7:0]            sym_a, sym_b;
    logic                  pair_bad;
    logic [BW-1:0]         div_t;
    logic                  div_ge;
    logic [RW-1:0]         div_rem;
    logic [VALUE_BITS-1:0] div_q;
    logic [VALUE_BITS-1:0] raw;
    logic                  push;
    logic [SW-1:0]         top_idx;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    assign base_bad = (r_base_size < 5'd2) || (r_base_size > 5'(MAX_BASE));
    assign last_idx = RW'(r_base_size - 5'd1);
    assign radix    = r_base_size[BW-1:0];

    // pair compare: same index checks for a sign character
    assign sym_a    = sirt_pkg::sym_at(r_sym_lo, r_sym_hi, 4'(r_i));
    assign sym_b    = sirt_pkg::sym_at(r_sym_lo, r_sym_hi, 4'(r_j));
    assign pair_bad = (r_i == r_j)
                    ? ((sym_a == sirt_pkg::CH_MINUS) || (sym_a == sirt_pkg::CH_PLUS))
                    : (sym_a == sym_b);

    // one restoring division step
    assign div_t   = {r_rem, r_q[VALUE_BITS-1]};
    assign div_ge  = (div_t >= radix);
    assign div_rem = div_ge ? RW'(div_t - radix) : RW'(div_t);
    assign div_q   = {r_q[VALUE_BITS-2:0], div_ge};

    assign raw     = i_value[VALUE_BITS-1:0];
    assign top_idx = SW'(r_nd - NW'(1));
    assign push    = (r_state == ST_DIV) && (r_bit == '0);

    // next-state logic
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_q       = r_q;
        n_rem     = r_rem;
        n_bit     = r_bit;
        n_nd      = r_nd;
        n_neg     = r_neg;
        n_o_valid = r_o_valid && i_stall;
        n_symbol  = r_symbol;
        n_last    = r_last;
        n_bad     = r_bad;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_neg = raw[VALUE_BITS-1];
                    n_q   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
                    n_i   = '0;
                    n_j   = '0;
                    n_state = base_bad ? ST_FLAG : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (pair_bad) begin
                    n_state = ST_FLAG;
                end else if (r_j == last_idx) begin
                    if (r_i == last_idx) begin
                        n_rem   = '0;
                        n_bit   = CW'(VALUE_BITS - 1);
                        n_nd    = '0;
                        n_state = ST_DIV;
                    end else begin
                        n_i = r_i + RW'(1);
                        n_j = r_i + RW'(1);
                    end
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            ST_DIV: begin
                n_q   = div_q;
                n_rem = div_rem;
                n_bit = r_bit - CW'(1);
                if (r_bit == '0) begin
                    n_nd  = r_nd + NW'(1);
                    n_rem = '0;
                    n_bit = CW'(VALUE_BITS - 1);
                    if (div_q == '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_bad     = 1'b0;
                    if (r_neg) begin
                        n_neg    = 1'b0;
                        n_symbol = sirt_pkg::CH_MINUS;
                        n_last   = 1'b0;
                    end else begin
                        n_nd     = r_nd - NW'(1);
                        n_symbol = sirt_pkg::sym_at(r_sym_lo, r_sym_hi,
                                                    4'(r_digits[top_idx]));
                        n_last   = (r_nd == NW'(1));
                        if (r_nd == NW'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLAG: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_symbol  = '0;
                    n_last    = 1'b1;
                    n_bad     = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_o_valid   <= 1'b0;
            r_nd        <= '0;
            r_base_size <= '0;
            r_sym_lo    <= '0;
            r_sym_hi    <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_nd      <= n_nd;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sirt_pkg::CFG_BASE_SIZE:    r_base_size <= i_cfg_data[4:0];
                    sirt_pkg::CFG_SYMBOLS_LOW:  r_sym_lo    <= i_cfg_data;
                    sirt_pkg::CFG_SYMBOLS_HIGH: r_sym_hi    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_neg    <= n_neg;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_bad    <= n_bad;
        if (push) begin
            r_digits[r_nd[SW-1:0]] <= div_rem;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_symbol       = r_symbol;
    assign o_last_char    = r_last;
    assign o_base_invalid = r_bad;

    // checks
    `AST_ALWAYS(a_nd_bound, i_clk, i_rst_n, r_nd <= NW'(VALUE_BITS), "digit stack overflow")
    `AST_IMPLY(a_rem_range, i_clk, i_rst_n, r_state == ST_DIV, BW'(r_rem) < radix,
               "remainder out of range")
    `AST_IMPLY(a_flag_form, i_clk, i_rst_n, o_valid && o_base_invalid,
               o_last_char && (o_symbol == 8'd0), "bad flagged result")
    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, r_state != ST_IDLE,
              "idle right after accept")
    `AST_IMPLY(a_emit_has_work, i_clk, i_rst_n, (r_state == ST_EMIT) && !r_neg, r_nd != '0,
               "emit with empty stack")

endmodule
